FILE: hdl/calendar_date_to_epoch_seconds_assert.svh
// Assertion macros shared by the date conversion modules.
// CDTE_ASSERT expects clk and arst_n in scope; CDTE_ASSERT_RST expects clk.
`ifndef CALENDAR_DATE_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_DATE_TO_EPOCH_SECONDS_ASSERT_SVH

`ifndef SYNTHESIS
`define CDTE_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("cdte assertion failed");
`define CDTE_ASSERT_RST(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("cdte reset assertion failed");
`else
`define CDTE_ASSERT(name, prop)
`define CDTE_ASSERT_RST(name, prop)
`endif

`endif

FILE: hdl/cdte_pkg.sv
`timescale 1ns / 1ps

package cdte_pkg;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int EPOCH_W = 33;
	localparam int TOD_W   = 17;
	localparam int DAYS_W  = 20;
	localparam int ADJ_W   = 18;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
	localparam logic [9:0]        LEAPS_1969 = 10'd477;
	localparam logic [6:0]        ANY        = 7'd99;
	localparam logic [16:0]       SECS_DAY   = 17'd86400;
	localparam logic [TOD_W-1:0]  SECS_HOUR  = 17'd3600;
	localparam logic [TOD_W-1:0]  SECS_MIN   = 17'd60;
	localparam logic [15:0]       RECIP_25   = 16'd41944;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} date_t;

	typedef struct packed {
		logic               en;
		logic [MONTH_W-1:0] sm;
		logic [6:0]         sd;
		logic [6:0]         sh;
		logic [MONTH_W-1:0] em;
		logic [6:0]         ed;
		logic [6:0]         eh;
	} window_t;

	typedef struct packed {
		logic               after_epoch;
		logic [YEAR_W-1:0]  years;
		logic [9:0]         q4;
		logic [5:0]         q100;
		logic [3:0]         q400;
		logic               leap;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		window_t            win;
		logic [TOD_W-1:0]   tod;
	} split_t;

	typedef struct packed {
		logic [DAYS_W-1:0]        days;
		logic signed [ADJ_W-1:0]  tod_adj;
		logic                     summer;
	} count_t;

	// x / 25 for x below 1024
	function automatic logic [5:0] div25(input logic [9:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'(RECIP_25);
		return p[25:20];
	endfunction

	function automatic window_t win(input logic [MONTH_W-1:0] sm, input logic [6:0] sd,
			input logic [6:0] sh, input logic [MONTH_W-1:0] em, input logic [6:0] ed,
			input logic [6:0] eh);
		window_t w;
		w.en = 1'b1;
		w.sm = sm;
		w.sd = sd;
		w.sh = sh;
		w.em = em;
		w.ed = ed;
		w.eh = eh;
		return w;
	endfunction

	function automatic window_t summer_window(input logic [YEAR_W-1:0] y);
		window_t w;
		w = '0;
		case (y)
			12'd1980:
				w = win(4'd4, 7'd6, 7'd3, 4'd9, ANY, ANY);
			12'd1982, 12'd1993:
				w = win(4'd3, ANY, ANY, 4'd9, 7'd26, 7'd2);
			12'd1983, 12'd1988, 12'd1994:
				w = win(4'd3, ANY, ANY, 4'd9, 7'd25, 7'd2);
			12'd1984, 12'd1990:
				w = win(4'd3, 7'd25, 7'd3, 4'd9, ANY, ANY);
			12'd1989, 12'd1995:
				w = win(4'd3, 7'd26, 7'd3, 4'd9, 7'd24, 7'd2);
			12'd1996, 12'd1999, 12'd2002, 12'd2004, 12'd2016, 12'd2027:
				w = win(4'd3, ANY, ANY, 4'd10, ANY, ANY);
			12'd1997, 12'd2003, 12'd2008, 12'd2014, 12'd2025, 12'd2031:
				w = win(4'd3, ANY, ANY, 4'd10, 7'd26, 7'd2);
			12'd1998, 12'd2009, 12'd2015, 12'd2020, 12'd2026:
				w = win(4'd3, ANY, ANY, 4'd10, 7'd25, 7'd2);
			12'd2000, 12'd2006, 12'd2017, 12'd2023, 12'd2028:
				w = win(4'd3, 7'd26, 7'd3, 4'd10, ANY, ANY);
			12'd2001, 12'd2007, 12'd2012, 12'd2018, 12'd2029:
				w = win(4'd3, 7'd25, 7'd3, 4'd10, ANY, ANY);
			default: begin
				if (y > 12'd1980 && y < 12'd2005)
					w = win(4'd4, 7'd0, 7'd0, 4'd10, 7'd0, 7'd0);
				else if (y >= 12'd2005)
					w = win(4'd3, ANY, ANY, 4'd10, 7'd27, 7'd3);
				else
					w = '0;
			end
		endcase
		return w;
	endfunction

	// days in the months before m, February counted as 28
	function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [8:0] d;
		case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			4'd13:   d = 9'd365;
			4'd14:   d = 9'd396;
			4'd15:   d = 9'd427;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: hdl/cdte_split.sv
`timescale 1ns / 1ps

module cdte_split (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cdte_pkg::date_t  in_date,
	output logic             out_valid,
	input  logic             out_ready,
	output cdte_pkg::split_t out_data
);

	logic             v_s1;
	cdte_pkg::split_t p_s1;
	cdte_pkg::split_t nxt;
	logic             rdy_s1;
	logic [11:0]      ym1;
	logic [9:0]       y4;
	logic [9:0]       y16;
	logic [5:0]       y4_q;
	logic [5:0]       y16_q;
	logic [10:0]      y4_back;
	logic [10:0]      y16_back;

	assign rdy_s1   = !v_s1 || out_ready;
	assign in_ready = rdy_s1;

	always_comb begin
		ym1      = in_date.year - 12'd1;
		y4       = in_date.year[11:2];
		y16      = {2'b00, in_date.year[11:4]};
		y4_q     = cdte_pkg::div25(y4);
		y16_q    = cdte_pkg::div25(y16);
		y4_back  = 11'(y4_q) * 11'd25;
		y16_back = 11'(y16_q) * 11'd25;

		nxt.after_epoch = in_date.year > cdte_pkg::EPOCH_YEAR;
		nxt.years       = in_date.year - cdte_pkg::EPOCH_YEAR;
		nxt.q4          = ym1[11:2];
		nxt.q100        = cdte_pkg::div25(ym1[11:2]);
		nxt.q400        = 4'(cdte_pkg::div25({2'b00, ym1[11:4]}));
		nxt.leap        = (in_date.year[1:0] == 2'b00 && y4_back != 11'(y4)) ||
				(in_date.year[3:0] == 4'b0000 && y16_back == 11'(y16));
		nxt.month       = in_date.month;
		nxt.day         = in_date.day;
		nxt.hour        = in_date.hour;
		nxt.win         = cdte_pkg::summer_window(in_date.year);
		nxt.tod         = 17'(in_date.second) +
				17'(in_date.minute) * cdte_pkg::SECS_MIN +
				17'(in_date.hour) * cdte_pkg::SECS_HOUR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			p_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = p_s1;

`include "calendar_date_to_epoch_seconds_assert.svh"

	`CDTE_ASSERT(a_accept_loads, (in_valid && in_ready) |=> v_s1)

endmodule

FILE: hdl/cdte_count.sv
`timescale 1ns / 1ps

module cdte_count (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cdte_pkg::split_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output cdte_pkg::count_t out_data
);

	logic                    v_s2;
	logic                    rdy_s2;
	logic [19:0]             yd_s2;
	logic [9:0]              ladj_s2;
	logic [8:0]              mdays_s2;
	logic                    summer_s2;
	logic [16:0]             tod_s2;
	logic                    v_s3;
	logic                    rdy_s3;
	cdte_pkg::count_t        p_s3;

	logic [19:0]             yd;
	logic [10:0]             ladj_w;
	logic [8:0]              mdays;
	logic                    after_start;
	logic                    before_end;
	logic [6:0]              d7;
	logic [6:0]              h7;
	cdte_pkg::window_t       w;
	cdte_pkg::count_t        nxt3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_comb begin
		w      = in_data.win;
		d7     = 7'(in_data.day);
		h7     = 7'(in_data.hour);
		yd     = in_data.after_epoch ? 20'(in_data.years) * 20'd365 : 20'd0;
		ladj_w = 11'(in_data.q4) - 11'(in_data.q100) + 11'(in_data.q400) -
				11'(cdte_pkg::LEAPS_1969);
		mdays  = cdte_pkg::days_before_month(in_data.month) +
				9'(in_data.leap && in_data.month >= 4'd3) + 9'(in_data.day);
		after_start = (in_data.month > w.sm) ||
				(in_data.month == w.sm && d7 > w.sd) ||
				(in_data.month == w.sm && d7 == w.sd && h7 >= w.sh);
		before_end  = (in_data.month < w.em) ||
				(in_data.month == w.em && d7 < w.ed) ||
				(in_data.month == w.em && d7 == w.ed && h7 < w.eh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			yd_s2     <= yd;
			ladj_s2   <= in_data.after_epoch ? ladj_w[9:0] : 10'd0;
			mdays_s2  <= mdays;
			summer_s2 <= w.en && after_start && before_end;
			tod_s2    <= in_data.tod;
		end
	end

	// day count is offset by one; the local offset and the day offset fold into tod_adj
	always_comb begin
		nxt3.days    = yd_s2 + 20'(ladj_s2) + 20'(mdays_s2);
		nxt3.tod_adj = $signed(18'(tod_s2) - 18'd90000 -
				(summer_s2 ? 18'(cdte_pkg::SECS_HOUR) : 18'd0));
		nxt3.summer  = summer_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			p_s3 <= nxt3;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = p_s3;

`include "calendar_date_to_epoch_seconds_assert.svh"

	`CDTE_ASSERT(a_summer_span, (v_s2 && summer_s2) |-> (mdays_s2 >= 9'd59 && mdays_s2 <= 9'd305))

endmodule

FILE: hdl/cdte_scale.sv
`timescale 1ns / 1ps

module cdte_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cdte_pkg::count_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [32:0]      epoch,
	output logic             summer
);

	logic                    v_s4;
	logic                    rdy_s4;
	logic [32:0]             dsec_s4;
	logic signed [17:0]      adj_s4;
	logic                    summer_s4;
	logic                    v_s5;
	logic                    rdy_s5;
	logic [32:0]             epoch_s5;
	logic                    summer_s5;
	logic [36:0]             prod;

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;
	assign prod     = 37'(in_data.days) * 37'(cdte_pkg::SECS_DAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4)
				v_s4 <= in_valid;
			if (rdy_s5)
				v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			dsec_s4   <= prod[32:0];
			adj_s4    <= in_data.tod_adj;
			summer_s4 <= in_data.summer;
		end
		if (rdy_s5 && v_s4) begin
			epoch_s5  <= dsec_s4 + {{15{adj_s4[17]}}, adj_s4};
			summer_s5 <= summer_s4;
		end
	end

	assign out_valid = v_s5;
	assign epoch     = epoch_s5;
	assign summer    = summer_s5;

`include "calendar_date_to_epoch_seconds_assert.svh"

	`CDTE_ASSERT(a_s4_holds, (v_s4 && !rdy_s4) |=> (v_s4 && $stable(dsec_s4)))

endmodule

FILE: hdl/calendar_date_to_epoch_seconds.sv
`timescale 1ns / 1ps
// Path: five register stages from the input accept to m_tvalid high
// (split, two count stages, day scaling multiply, output register).
// Throughput: one item per cycle; each stage holds under backpressure and bubbles close up.
// Reset: arst_n low clears all stage valid bits at once; the output shows no item.

module calendar_date_to_epoch_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], second[37:32], zero
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// epoch_seconds[32:0], zero
	output logic [39:0] m_tdata,
	// summer_time[0]
	output logic [0:0]  m_tuser
);

	cdte_pkg::date_t  date;
	cdte_pkg::split_t split_d;
	cdte_pkg::count_t count_d;
	logic             split_v;
	logic             split_r;
	logic             count_v;
	logic             count_r;
	logic [32:0]      epoch;
	logic             summer;

	always_comb begin
		date.year   = s_tdata[11:0];
		date.month  = s_tdata[15:12];
		date.day    = s_tdata[20:16];
		date.hour   = s_tdata[25:21];
		date.minute = s_tdata[31:26];
		date.second = s_tdata[37:32];
	end

	cdte_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_date   (date),
		.out_valid (split_v),
		.out_ready (split_r),
		.out_data  (split_d)
	);

	cdte_count u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_v),
		.in_ready  (split_r),
		.in_data   (split_d),
		.out_valid (count_v),
		.out_ready (count_r),
		.out_data  (count_d)
	);

	cdte_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (count_v),
		.in_ready  (count_r),
		.in_data   (count_d),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.epoch     (epoch),
		.summer    (summer)
	);

	assign m_tdata = {7'd0, epoch};
	assign m_tuser = summer;

`include "calendar_date_to_epoch_seconds_assert.svh"

	`CDTE_ASSERT_RST(a_reset_empty, !arst_n |-> !m_tvalid)

endmodule
